// File: rtl/dv64_pkg.sv
package dv64_pkg;

	// Width of each dividend, divisor, quotient and remainder field
	localparam int unsigned FIELD_W = 64;

	// Default working width of the divider
	localparam int unsigned DATA_WIDTH_DEF = 64;

	// Stream payload widths
	localparam int unsigned IN_TDATA_W  = 2 * FIELD_W;
	localparam int unsigned OUT_TDATA_W = 2 * FIELD_W;
	localparam int unsigned OUT_TUSER_W = 1;

endpackage

// File: rtl/unsigned_divide_64_by_64.sv
// Channel   Dir  Beat contents (low bit first)                    Handshake
// s_axis    in   tdata: dividend[63:0], divisor[127:64]           s_axis_tvalid/tready
// m_axis    out  tdata: quotient[63:0], remainder[127:64]         m_axis_tvalid/tready
//                tuser: divide_by_zero[0]
//
// One division enters per cycle while s_axis_tready is high; each passes through
// one registered pipeline stage per quotient bit, each one DATA_WIDTH-bit subtract.
// Reset empties every stage; the payload registers are not reset.
// A stalled output holds its beat; upstream stages keep filling empty slots,
// so input is refused only when every stage holds a beat.
module unsigned_divide_64_by_64 #(
	parameter int unsigned DATA_WIDTH = dv64_pkg::DATA_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// dividend[63:0], divisor[127:64]
	input  logic [dv64_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// quotient[63:0], remainder[127:64]
	output logic [dv64_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// divide_by_zero[0]
	output logic [dv64_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
	import dv64_pkg::*;

	logic                  vld_w  [0:DATA_WIDTH];
	logic                  rdy_w  [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] rem_w  [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] numq_w [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] den_w  [0:DATA_WIDTH];
	logic                  dbz_w  [0:DATA_WIDTH];

	logic [DATA_WIDTH-1:0] quo_fin;
	logic [DATA_WIDTH-1:0] rem_fin;

	// Feed the first stage; bits above DATA_WIDTH are ignored
	assign vld_w[0]      = s_axis_tvalid;
	assign s_axis_tready = rdy_w[0];
	assign rem_w[0]      = '0;
	assign numq_w[0]     = s_axis_tdata[DATA_WIDTH-1:0];
	assign den_w[0]      = s_axis_tdata[FIELD_W +: DATA_WIDTH];
	assign dbz_w[0]      = (s_axis_tdata[FIELD_W +: DATA_WIDTH] == '0);

	// One stage per quotient bit, most significant first
	for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_stage
		dv64_stage #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.vld_in   (vld_w[k]),
			.rdy_up   (rdy_w[k]),
			.rem_in   (rem_w[k]),
			.numq_in  (numq_w[k]),
			.den_in   (den_w[k]),
			.dbz_in   (dbz_w[k]),
			.vld_out  (vld_w[k+1]),
			.rdy_dn   (rdy_w[k+1]),
			.rem_out  (rem_w[k+1]),
			.numq_out (numq_w[k+1]),
			.den_out  (den_w[k+1]),
			.dbz_out  (dbz_w[k+1])
		);
	end

	// Zero the results on a zero divisor
	assign quo_fin = dbz_w[DATA_WIDTH] ? '0 : numq_w[DATA_WIDTH];
	assign rem_fin = dbz_w[DATA_WIDTH] ? '0 : rem_w[DATA_WIDTH];

	// Drive the output beat from the last stage
	assign rdy_w[DATA_WIDTH] = m_axis_tready;
	assign m_axis_tvalid     = vld_w[DATA_WIDTH];
	assign m_axis_tdata      = {FIELD_W'(rem_fin), FIELD_W'(quo_fin)};
	assign m_axis_tuser      = OUT_TUSER_W'(dbz_w[DATA_WIDTH]);

endmodule

// File: rtl/dv64_stage.sv
module dv64_stage #(
	parameter int unsigned DATA_WIDTH = dv64_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// upstream side
	input  logic                  vld_in,
	output logic                  rdy_up,
	input  logic [DATA_WIDTH-1:0] rem_in,
	input  logic [DATA_WIDTH-1:0] numq_in,
	input  logic [DATA_WIDTH-1:0] den_in,
	input  logic                  dbz_in,
	// downstream side
	output logic                  vld_out,
	input  logic                  rdy_dn,
	output logic [DATA_WIDTH-1:0] rem_out,
	output logic [DATA_WIDTH-1:0] numq_out,
	output logic [DATA_WIDTH-1:0] den_out,
	output logic                  dbz_out
);
	import dv64_pkg::*;

	logic                  bit_in;
	logic [DATA_WIDTH-1:0] cand;
	logic [DATA_WIDTH:0]   diff;
	logic                  ge;
	logic [DATA_WIDTH-1:0] rem_nx;
	logic [DATA_WIDTH-1:0] numq_nx;

	logic                  vld_s;
	logic [DATA_WIDTH-1:0] rem_s;
	logic [DATA_WIDTH-1:0] numq_s;
	logic [DATA_WIDTH-1:0] den_s;
	logic                  dbz_s;

	// Shift the next dividend bit into the partial remainder, kept to DATA_WIDTH bits
	assign bit_in = numq_in[DATA_WIDTH-1];
	assign cand   = {rem_in[DATA_WIDTH-2:0], bit_in};

	// Trial subtract; no borrow means the quotient bit is set
	assign diff    = {1'b0, cand} - {1'b0, den_in};
	assign ge      = ~diff[DATA_WIDTH];
	assign rem_nx  = ge ? diff[DATA_WIDTH-1:0] : cand;
	// Dividend bits leave at the top while quotient bits enter at the bottom
	assign numq_nx = {numq_in[DATA_WIDTH-2:0], ge};

	// Take a new beat when this stage is empty or its beat moves on
	assign rdy_up = ~vld_s | rdy_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (rdy_up) begin
			vld_s <= vld_in;
		end
	end

	// Load the payload only with a valid beat
	always_ff @(posedge clk) begin
		if (rdy_up && vld_in) begin
			rem_s  <= rem_nx;
			numq_s <= numq_nx;
			den_s  <= den_in;
			dbz_s  <= dbz_in;
		end
	end

	assign vld_out  = vld_s;
	assign rem_out  = rem_s;
	assign numq_out = numq_s;
	assign den_out  = den_s;
	assign dbz_out  = dbz_s;

endmodule

// File: rtl/dv64_chk.sv
module dv64_chk #(
	parameter int unsigned DATA_WIDTH = dv64_pkg::DATA_WIDTH_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [dv64_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [dv64_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [dv64_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
	import dv64_pkg::*;

	// Hold no output beat while in reset
	a_rst_empty: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

	// Hold a stalled output beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled output beat changed");

	// On a zero divisor flagged in tuser, the results must be zero
	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("nonzero result on divide by zero");

	// Advance the whole pipe when the output side is ready
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input blocked while output ready");

	// Hold known payload on every offered input beat
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid |-> !$isunknown(s_axis_tdata))
		else $error("unknown input payload");

endmodule

bind unsigned_divide_64_by_64 dv64_chk #(.DATA_WIDTH(DATA_WIDTH)) u_dv64_chk (.*);
